FILE: hw/rtl/lsgc_pkg.sv
// Shared types and constants for the lidar scan to grid cell core.
// No dependencies; imported by every module of the block.
package lsgc_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned XY_W         = 20;
  localparam int unsigned Z_W          = 24;
  localparam int unsigned RANGE_W      = 16;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned FRAC_SHIFT   = 20;
  localparam int unsigned P_W          = RANGE_W + 1 + XY_W;
  localparam int unsigned D_W          = 40;
  localparam int unsigned G_W          = D_W - FRAC_SHIFT;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned COL_W        = 8;
  localparam int unsigned ROW_W        = 7;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = XY_W'(39797);

  localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    24'sd2097152, 24'sd1238021, 24'sd654137, 24'sd332050,
    24'sd166669,  24'sd83416,   24'sd41718,  24'sd20860,
    24'sd10430,   24'sd5215,    24'sd2608,   24'sd1304,
    24'sd652,     24'sd326,     24'sd163,    24'sd81
  };

  localparam logic [ANGLE_W-1:0] DEF_START_ANGLE = 16'd0;
  localparam logic [ANGLE_W-1:0] DEF_ANGLE_STEP  = 16'd182;
  localparam logic [RANGE_W-1:0] DEF_RANGE_LOWER = 16'd0;
  localparam logic [RANGE_W-1:0] DEF_RANGE_UPPER = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 2'd0,
    REG_ANGLE_STEP  = 2'd1,
    REG_RANGE_LOWER = 2'd2,
    REG_RANGE_UPPER = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_PLOTTED  = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OFF_GRID = 2'd2
  } status_e;

  // Sideband that travels with a sample through the CORDIC row.
  typedef struct packed {
    logic [RANGE_W-1:0] range;
    logic [1:0]         quad;
    logic               last;
    logic               reject;
  } side_t;

endpackage

FILE: hw/rtl/lsgc_stream_if.sv
// Valid/ready stream interfaces for sample input and cell result output.
// Depends on nothing; used by the top level and the binning stage.
interface lsgc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_sample;
  logic        scan_last;

  modport source (output valid, range_sample, scan_last, input ready);
  modport sink   (input valid, range_sample, scan_last, output ready);
endinterface

interface lsgc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_column;
  logic [6:0] cell_row;
  logic [1:0] status;
  logic       scan_done;

  modport source (output valid, cell_column, cell_row, status, scan_done, input ready);
  modport sink   (input valid, cell_column, cell_row, status, scan_done, output ready);
endinterface

FILE: hw/rtl/lsgc_cell.sv
// One CORDIC rotation cell: a single micro-rotation with a fixed shift.
// Depends on lsgc_pkg; instantiated in a row by the top level.
module lsgc_cell import lsgc_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  input  side_t                  side_i,
  output logic                   vld_o,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o,
  output logic signed [Z_W-1:0]  z_o,
  output side_t                  side_o
);

  localparam logic signed [Z_W-1:0] ATAN = ATAN_TURNS[STEP];

  logic                   vld_q;
  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  side_t                  side_q;
  logic signed [XY_W-1:0] dx, dy;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!z_i[Z_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

FILE: hw/rtl/lsgc_bin.sv
// Quadrant fix-up, range scaling, truncation and grid bounds check.
// Depends on lsgc_pkg and lsgc_out_if; drives the result channel.
module lsgc_bin import lsgc_pkg::*; #(
  parameter int unsigned GRID_COLS = 200,
  parameter int unsigned GRID_ROWS = 100
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  side_t                  side_i,
  lsgc_out_if.source             out_o,
  output logic                   done_o
);

  localparam logic signed [D_W-1:0] CX = D_W'(longint'(GRID_COLS / 2) << FRAC_SHIFT);
  localparam logic signed [D_W-1:0] CY = D_W'(longint'(GRID_ROWS / 2) << FRAC_SHIFT);
  localparam logic signed [G_W-1:0] GW = G_W'(GRID_COLS);
  localparam logic signed [G_W-1:0] GH = G_W'(GRID_ROWS);

  logic signed [XY_W-1:0] cos_v, sin_v;
  logic signed [RANGE_W:0] rng_s;

  logic                  p_vld_q;
  logic signed [P_W-1:0] px_q, py_q;
  logic                  p_last_q, p_rej_q;

  logic                  d_vld_q;
  logic signed [D_W-1:0] dcol_q, drow_q;
  logic                  d_last_q, d_rej_q;

  logic                  move;
  logic signed [G_W-1:0] gcol, grow;
  logic                  in_grid;
  status_e               status_d;
  logic [COL_W-1:0]      col_d;
  logic [ROW_W-1:0]      row_d;

  logic                  out_vld_q;
  logic [COL_W-1:0]      col_q;
  logic [ROW_W-1:0]      row_q;
  status_e               status_q;
  logic                  done_q;

  always_comb begin
    unique case (side_i.quad)
      2'd0: begin cos_v = x_i;  sin_v = y_i;  end
      2'd1: begin cos_v = -y_i; sin_v = x_i;  end
      2'd2: begin cos_v = -x_i; sin_v = -y_i; end
      default: begin cos_v = y_i; sin_v = -x_i; end
    endcase
  end

  assign rng_s = $signed({1'b0, side_i.range});

  // stage P: polar to cartesian products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      px_q     <= rng_s * cos_v;
      py_q     <= rng_s * sin_v;
      p_last_q <= side_i.last;
      p_rej_q  <= side_i.reject;
    end
  end

  // stage D: offset from grid center; holds while output is stalled
  assign move = d_vld_q && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (p_vld_q) begin
      d_vld_q <= 1'b1;
    end else if (move) begin
      d_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      dcol_q   <= CX - {{(D_W-P_W){py_q[P_W-1]}}, py_q};
      drow_q   <= CY - {{(D_W-P_W){px_q[P_W-1]}}, px_q};
      d_last_q <= p_last_q;
      d_rej_q  <= p_rej_q;
    end
  end

  // truncate toward zero
  assign gcol = $signed(dcol_q[D_W-1:FRAC_SHIFT])
              + G_W'(dcol_q[D_W-1] && (|dcol_q[FRAC_SHIFT-1:0]));
  assign grow = $signed(drow_q[D_W-1:FRAC_SHIFT])
              + G_W'(drow_q[D_W-1] && (|drow_q[FRAC_SHIFT-1:0]));

  assign in_grid = !gcol[G_W-1] && (gcol < GW) && !grow[G_W-1] && (grow < GH);

  always_comb begin
    priority if (d_rej_q) begin
      status_d = ST_RANGE;
    end else if (in_grid) begin
      status_d = ST_PLOTTED;
    end else begin
      status_d = ST_OFF_GRID;
    end
    col_d = (status_d == ST_PLOTTED) ? gcol[COL_W-1:0] : '0;
    row_d = (status_d == ST_PLOTTED) ? grow[ROW_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      col_q    <= col_d;
      row_q    <= row_d;
      status_q <= status_d;
      done_q   <= d_last_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.cell_column = col_q;
  assign out_o.cell_row    = row_q;
  assign out_o.status      = status_q;
  assign out_o.scan_done   = done_q;
  assign done_o            = move;

endmodule

FILE: hw/rtl/lidar_scan_to_grid_cell_core.sv
// Lidar range sample to occupancy grid cell core: top level.
// Depends on lsgc_pkg, lsgc_stream_if, lsgc_cell and lsgc_bin.
//
// One sample is in flight at a time. A sample walks through the angle stage,
// the row of 16 CORDIC rotation cells and three binning stages, and the next
// sample is accepted the cycle after its result is loaded into the output
// register, which waits while the output is stalled; a new sample is thus
// taken only once the last one is through. A finished result waits in the
// output register without stopping the next sample from being accepted.
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// only while idle; the block itself does not enforce this.
module lidar_scan_to_grid_cell_core import lsgc_pkg::*; #(
  parameter int unsigned GRID_COLS = 200,
  parameter int unsigned GRID_ROWS = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  lsgc_in_if.sink               in_i,
  lsgc_out_if.source            out_o
);

  logic [ANGLE_W-1:0] start_q, step_q;
  logic [RANGE_W-1:0] lower_q, upper_q;
  logic [ANGLE_W-1:0] index_q;

  logic busy_q;
  logic accept;
  logic item_done;

  logic               s0_vld_q;
  logic [ANGLE_W-1:0] angle_q;
  logic [RANGE_W-1:0] s0_range_q;
  logic               s0_last_q, s0_rej_q;

  logic [ANGLE_W-1:0]    prod;
  logic [ANGLE_W-1:0]    shifted;
  logic signed [14:0]    resid;

  logic                   c_vld  [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_x    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_y    [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  c_z    [CORDIC_STEPS+1];
  side_t                  c_side [CORDIC_STEPS+1];

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= DEF_START_ANGLE;
      step_q  <= DEF_ANGLE_STEP;
      lower_q <= DEF_RANGE_LOWER;
      upper_q <= DEF_RANGE_UPPER;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_ANGLE: start_q <= cfg_wdata_i;
        REG_ANGLE_STEP:  step_q  <= cfg_wdata_i;
        REG_RANGE_LOWER: lower_q <= cfg_wdata_i;
        REG_RANGE_UPPER: upper_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      index_q  <= '0;
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= accept;
      if (accept) begin
        busy_q  <= 1'b1;
        index_q <= in_i.scan_last ? '0 : index_q + 1'b1;
      end else if (item_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign prod = ANGLE_W'(index_q * step_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      angle_q    <= start_q + prod;
      s0_range_q <= in_i.range_sample;
      s0_last_q  <= in_i.scan_last;
      s0_rej_q   <= (in_i.range_sample < lower_q) || (in_i.range_sample > upper_q);
    end
  end

  // nearest quadrant and residual in [-1/8, 1/8) turn
  assign shifted = angle_q + 16'h2000;
  assign resid   = $signed({1'b0, shifted[13:0]}) - 15'sh2000;

  assign c_vld[0]         = s0_vld_q;
  assign c_x[0]           = CORDIC_GAIN_INV;
  assign c_y[0]           = '0;
  assign c_z[0]           = {resid[14], resid, 8'h00};
  assign c_side[0].range  = s0_range_q;
  assign c_side[0].quad   = shifted[15:14];
  assign c_side[0].last   = s0_last_q;
  assign c_side[0].reject = s0_rej_q;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    lsgc_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (c_vld[g]),
      .x_i    (c_x[g]),
      .y_i    (c_y[g]),
      .z_i    (c_z[g]),
      .side_i (c_side[g]),
      .vld_o  (c_vld[g+1]),
      .x_o    (c_x[g+1]),
      .y_o    (c_y[g+1]),
      .z_o    (c_z[g+1]),
      .side_o (c_side[g+1])
    );
  end

  lsgc_bin #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_bin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c_vld[CORDIC_STEPS]),
    .x_i    (c_x[CORDIC_STEPS]),
    .y_i    (c_y[CORDIC_STEPS]),
    .side_i (c_side[CORDIC_STEPS]),
    .out_o  (out_o),
    .done_o (item_done)
  );

endmodule
